// File: rtl/core/ubl_pkg.sv
// Shared types and constants for the USB packet buffer layout block.
// No dependencies; every module of the block imports this package.
package ubl_pkg;

  localparam int OFFSET_W = 12;   // packet memory byte offset
  localparam int SIZE_W   = 11;   // one buffer size, up to 1024 bytes
  localparam int QDEPTH   = 2;    // entries in the front-to-back queue

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_DOUBLE_BULK = 2'd0;
  localparam logic [1:0] CFG_IDX_ISOCHRONOUS = 2'd1;

  localparam logic [15:0] DOUBLE_BULK_RESET = 16'h0100;
  localparam logic [15:0] ISOCHRONOUS_RESET = 16'h0400;

  localparam logic [9:0]        RX_SIZE_MAX    = 10'd1022;
  localparam logic [SIZE_W-1:0] CRC_BYTES      = 11'd2;
  localparam logic [SIZE_W-1:0] RX_SMALL_LIMIT = 11'd63;
  localparam logic [SIZE_W-1:0] EVEN_MASK      = 11'h7FE;
  localparam logic [SIZE_W-1:0] BLK32_MASK     = 11'h7E0;
  localparam logic [SIZE_W-1:0] BLK32_ROUND    = 11'd31;
  localparam logic [SIZE_W-1:0] BLK32_BYTES    = 11'd32;
  localparam logic [15:0]       RX_BLK32_FLAG  = 16'h8000;

  typedef struct packed {
    logic        first;
    logic [2:0]  ep_index;
    logic [15:0] ep_type;
    logic [9:0]  tx_size;
    logic [9:0]  rx_size;
  } ubl_in_t;

  typedef struct packed {
    logic [11:0] tx_addr;
    logic [11:0] rx_addr;
    logic [15:0] tx_count_word;
    logic [15:0] rx_count_word;
    logic [15:0] ep_reg_value;
    logic        overflow;
  } ubl_out_t;

  // Classified endpoint, handed from front to back through the queue
  typedef struct packed {
    logic              first;
    logic [SIZE_W-1:0] size_a;
    logic [SIZE_W-1:0] size_b;
    logic [15:0]       tx_count_word;
    logic [15:0]       rx_count_word;
    logic [15:0]       ep_reg_value;
  } ubl_job_t;

  // Layout state as seen from outside the back stage
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic                ovf;
  } ubl_status_t;

endpackage

// File: rtl/core/ubl_front.sv
// Front stage: type code registers and endpoint classification.
// Depends on ubl_pkg; rounds buffer sizes and builds count words.
module ubl_front
  import ubl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  ubl_in_t     in_item,
  output ubl_job_t    job
);

  logic [15:0] double_bulk_r;
  logic [15:0] isochronous_r;

  logic [9:0]        rx_clamp;
  logic [SIZE_W-1:0] rx_raw;
  logic [SIZE_W-1:0] rx_sz;
  logic [SIZE_W-1:0] rx_blk;
  logic [15:0]       rx_code;
  logic [SIZE_W-1:0] tx_even;
  logic              is_double;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      double_bulk_r <= DOUBLE_BULK_RESET;
      isochronous_r <= ISOCHRONOUS_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDX_DOUBLE_BULK: double_bulk_r <= cfg_data;
        CFG_IDX_ISOCHRONOUS: isochronous_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // receive buffer: clamp, add CRC, round, encode
    rx_clamp = (in_item.rx_size > RX_SIZE_MAX) ? RX_SIZE_MAX : in_item.rx_size;
    rx_raw   = {1'b0, rx_clamp} + CRC_BYTES;
    rx_blk   = '0;
    if (rx_raw < RX_SMALL_LIMIT) begin
      rx_sz   = (rx_raw + 11'd1) & EVEN_MASK;
      rx_code = {rx_sz[6:0], 9'b0};
    end else begin
      rx_sz   = (rx_raw + BLK32_ROUND) & BLK32_MASK;
      rx_blk  = rx_sz - BLK32_BYTES;
      rx_code = RX_BLK32_FLAG | {rx_blk, 5'b0};
    end

    tx_even   = ({1'b0, in_item.tx_size} + 11'd1) & EVEN_MASK;
    is_double = (in_item.ep_type == double_bulk_r) || (in_item.ep_type == isochronous_r);

    job.first        = in_item.first;
    job.ep_reg_value = in_item.ep_type | {13'b0, in_item.ep_index};
    if (is_double) begin
      if (in_item.tx_size == 10'd0) begin
        job.size_a        = rx_sz;
        job.size_b        = rx_sz;
        job.tx_count_word = rx_code;
        job.rx_count_word = rx_code;
      end else begin
        job.size_a        = tx_even;
        job.size_b        = tx_even;
        job.tx_count_word = '0;
        job.rx_count_word = '0;
      end
    end else begin
      job.size_a        = tx_even;
      job.size_b        = rx_sz;
      job.tx_count_word = '0;
      job.rx_count_word = rx_code;
    end
  end

endmodule

// File: rtl/core/ubl_queue.sv
// Two-entry queue between the front and back stages.
// Depends on ubl_pkg for the job type.
module ubl_queue
  import ubl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  ubl_job_t push_job,
  output logic     pop_valid,
  input  logic     pop_ready,
  output ubl_job_t pop_job
);

  ubl_job_t   q_r [QDEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  logic       pop;

  assign push_ready = (count_r != 2'(QDEPTH));
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = q_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/core/ubl_back.sv
// Back stage: running layout offset, overflow flag and output register.
// Depends on ubl_pkg; takes classified jobs from ubl_queue.
module ubl_back
  import ubl_pkg::*;
#(
  parameter int TABLE_BYTES      = 64,
  parameter int PACKET_MEM_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  ubl_job_t    job,
  output logic        out_valid,
  input  logic        out_ready,
  output ubl_out_t    out_data,
  output ubl_status_t status
);

  localparam logic [OFFSET_W-1:0] TABLE_OFS = OFFSET_W'(TABLE_BYTES);
  localparam logic [OFFSET_W:0]   MEM_END   = (OFFSET_W + 1)'(PACKET_MEM_BYTES);

  logic [OFFSET_W-1:0] offset_r;
  logic [OFFSET_W-1:0] offset_nxt;
  logic                ovf_r;
  logic                ovf_nxt;
  logic                out_valid_r;
  ubl_out_t            out_data_r;
  ubl_out_t            out_data_nxt;
  logic [OFFSET_W-1:0] base;
  logic                ovf_cur;
  logic [OFFSET_W:0]   end_ofs;
  logic                pop;

  assign job_ready = !out_valid_r || out_ready;
  assign pop       = job_valid && job_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign status    = '{offset: offset_r, ovf: ovf_r};

  always_comb begin
    base    = job.first ? TABLE_OFS : offset_r;
    ovf_cur = job.first ? 1'b0 : ovf_r;
    end_ofs = {1'b0, base} + {2'b0, job.size_a} + {2'b0, job.size_b};

    offset_nxt = base;
    ovf_nxt    = ovf_cur;
    if (end_ofs > MEM_END) begin
      ovf_nxt = 1'b1;
    end else if (!ovf_cur) begin
      offset_nxt = end_ofs[OFFSET_W-1:0];
    end

    out_data_nxt.tx_addr       = base;
    out_data_nxt.rx_addr       = base + {1'b0, job.size_a};
    out_data_nxt.tx_count_word = job.tx_count_word;
    out_data_nxt.rx_count_word = job.rx_count_word;
    out_data_nxt.ep_reg_value  = job.ep_reg_value;
    out_data_nxt.overflow      = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r    <= TABLE_OFS;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        offset_r    <= offset_nxt;
        ovf_r       <= ovf_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// File: rtl/core/usb_packet_buffer_layout.sv
// Top level of the USB packet buffer layout block.
// Depends on ubl_pkg, ubl_front, ubl_queue and ubl_back.
//
// Usage:
//   in_*   : one endpoint description per beat (first, index, type, sizes).
//   out_*  : one result beat per input beat, in order: buffer addresses,
//            count words, endpoint register value and the sticky overflow.
//   cfg_*  : writes the two double-buffered type codes (index 0: bulk,
//            index 1: isochronous); always ready, write only while idle.
// Path: a beat is classified combinationally and written into the queue
//   when accepted, then passes to the layout stage, whose output register
//   holds the result beat offered on out_*.
// Throughput: one beat per cycle while out_ready is high, set by the layout
//   stage, which does one offset add and memory-end compare per cycle and feeds the offset back.
// Reset: offset returns to the end of the descriptor table, overflow clears,
//   the queue empties and the type codes return to 0x0100 and 0x0400.
// Stall: while out_ready is low the result beat holds; the two-entry queue
//   keeps taking beats until full, then in_ready drops. There is no
//   combinational path from out_ready to in_ready.
module usb_packet_buffer_layout
  import ubl_pkg::*;
#(
  parameter int TABLE_BYTES      = 64,
  parameter int PACKET_MEM_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ubl_in_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ubl_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ubl_job_t    front_job;
  ubl_job_t    q_job;
  logic        q_valid;
  logic        q_ready;
  ubl_status_t status;

  // Classify the incoming beat and hold the type code registers
  ubl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_data),
    .job       (front_job)
  );

  // Decouple the front from output stalls
  ubl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_job   (front_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_job    (q_job)
  );

  // Advance the layout offset and register the result beat
  ubl_back #(
    .TABLE_BYTES      (TABLE_BYTES),
    .PACKET_MEM_BYTES (PACKET_MEM_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .status    (status)
  );

`ifndef SYNTHESIS
  // Offset never leaves the window between table end and memory end
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(status.offset) >= TABLE_BYTES) && (int'(status.offset) <= PACKET_MEM_BYTES))
    else $error("layout offset outside packet memory window");

  // Once overflowed, the offset freezes until a first beat restarts layout
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    status.ovf && !(q_valid && q_ready && q_job.first) |=> $stable(status.offset))
    else $error("layout offset moved while overflow set");

  // Overflow clears only through a first beat
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    status.ovf && !(q_valid && q_ready && q_job.first) |=> status.ovf)
    else $error("overflow cleared without a restart");
`endif

endmodule
